>>> design/skcc_pkg.sv
// Package: beat types, command format and codes for the sorted key collision classifier.
`timescale 1ns / 1ps

package skcc_pkg;

   // Request and response type codes
   localparam logic REQ_RECORD   = 1'b0;
   localparam logic REQ_FLUSH    = 1'b1;
   localparam logic KIND_TRIPLET = 1'b0;
   localparam logic KIND_ID      = 1'b1;

   // Command codes passed from the front to the back
   localparam logic [1:0] OP_UNIQUE  = 2'd0;
   localparam logic [1:0] OP_COLLIDE = 2'd1;
   localparam logic [1:0] OP_MEMBER  = 2'd2;

   // Default depth of the command queue
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic        req_type;
      logic [63:0] minimizer_key;
      logic [63:0] record_id;
      logic [31:0] position;
      logic [15:0] bucket_size;
   } req_beat_type;

   typedef struct packed {
      logic        result_kind;
      logic [63:0] out_key;
      logic [31:0] out_position;
      logic [15:0] out_size;
      logic [63:0] out_id;
      logic        last_of_run;
   } rsp_beat_type;

   // One queued command expands into one to three response beats
   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key;
      logic [31:0] position;
      logic [15:0] size;
      logic [63:0] first_id;
      logic [63:0] second_id;
   } cmd_type;

   // Handshake between the queue and its neighbors
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

>>> design/sorted_key_collision_classifier.sv
// A record that causes results is written to the queue as a command, then loaded into the output register.
// Throughput: one request per cycle; a unique or colliding-id command drains in one beat,
// a new collision in three beats, so the output port sets the sustained rate.
// The command queue (QueueDepth entries) absorbs bursts; req_ready drops when it is full.
// Reset (synchronous, active high) empties the held slot, the queue and the output register.
`timescale 1ns / 1ps

module sorted_key_collision_classifier #(
   parameter int QueueDepth = skcc_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  skcc_pkg::req_beat_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output skcc_pkg::rsp_beat_type  rsp_data
);

   skcc_pkg::cmd_type          push_cmd;
   skcc_pkg::cmd_type          head_cmd;
   skcc_pkg::queue_ctl_type    queue_ctl;
   skcc_pkg::queue_status_type queue_status;
   logic                       push;
   logic                       pop;

   assign queue_ctl.push = push;
   assign queue_ctl.pop  = pop;

   skcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_status.full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   skcc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (queue_ctl),
      .push_cmd (push_cmd),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   skcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (queue_status.not_empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> design/skcc_front.sv
// Front: holds one record, compares keys and issues commands into the queue.
`timescale 1ns / 1ps

module skcc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  skcc_pkg::req_beat_type    req_data,
   input  logic                      queue_full,
   output logic                      push,
   output skcc_pkg::cmd_type         push_cmd
);

   logic [63:0] held_key_ff, held_key_in;
   logic [63:0] held_id_ff, held_id_in;
   logic [31:0] held_position_ff, held_position_in;
   logic [15:0] held_size_ff, held_size_in;
   logic        in_run_ff, in_run_in;
   logic        accept;
   logic        key_match;
   logic        held_live;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign key_match = (req_data.minimizer_key == held_key_ff);
   assign held_live = (held_size_ff != 16'd0);

   // Classify the beat against the held record
   always_comb begin
      held_key_in      = held_key_ff;
      held_id_in       = held_id_ff;
      held_position_in = held_position_ff;
      held_size_in     = held_size_ff;
      in_run_in        = in_run_ff;
      push             = 1'b0;
      push_cmd.op        = skcc_pkg::OP_UNIQUE;
      push_cmd.key       = held_key_ff;
      push_cmd.position  = held_position_ff;
      push_cmd.size      = held_size_ff;
      push_cmd.first_id  = held_id_ff;
      push_cmd.second_id = req_data.record_id;
      if (accept) begin
         if (req_data.req_type == skcc_pkg::REQ_FLUSH) begin
            // Flush a held unique record, then empty the slot
            push             = !in_run_ff && held_live;
            held_key_in      = '0;
            held_id_in       = '0;
            held_position_in = '0;
            held_size_in     = '0;
            in_run_in        = 1'b0;
         end else if (in_run_ff && key_match) begin
            push              = 1'b1;
            push_cmd.op       = skcc_pkg::OP_MEMBER;
            push_cmd.first_id = req_data.record_id;
         end else if (!in_run_ff && held_live && key_match) begin
            // First repeat: open a collision run
            push             = 1'b1;
            push_cmd.op      = skcc_pkg::OP_COLLIDE;
            held_position_in = '0;
            held_size_in     = '0;
            in_run_in        = 1'b1;
         end else begin
            // New key: emit a live unique record, hold the new one
            push             = !in_run_ff && held_live;
            in_run_in        = 1'b0;
            held_key_in      = req_data.minimizer_key;
            held_id_in       = req_data.record_id;
            held_position_in = req_data.position;
            held_size_in     = req_data.bucket_size;
         end
      end
   end

   // Update the held record
   always_ff @(posedge clock) begin
      if (reset) begin
         held_key_ff      <= '0;
         held_id_ff       <= '0;
         held_position_ff <= '0;
         held_size_ff     <= '0;
         in_run_ff        <= 1'b0;
      end else begin
         held_key_ff      <= held_key_in;
         held_id_ff       <= held_id_in;
         held_position_ff <= held_position_in;
         held_size_ff     <= held_size_in;
         in_run_ff        <= in_run_in;
      end
   end

   // A run never coexists with a live unique record
   a_run_empty_slot: assert property (@(posedge clock) disable iff (reset)
      in_run_ff |-> (held_size_ff == 16'd0))
      else $error("collision run with live held record");

   // Nothing is issued into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("push into full queue");

endmodule

>>> design/skcc_queue.sv
// Queue: short command FIFO between the front and the back.
`timescale 1ns / 1ps

module skcc_queue #(
   parameter int Depth = skcc_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  skcc_pkg::queue_ctl_type     ctl,
   input  skcc_pkg::cmd_type           push_cmd,
   output skcc_pkg::cmd_type           head_cmd,
   output skcc_pkg::queue_status_type  status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   skcc_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign status.full      = (count_ff == CntW'(Depth));
   assign status.not_empty = (count_ff != '0);
   assign head_cmd         = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry storage
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> (count_ff != CntW'(Depth)))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> (count_ff != '0))
      else $error("queue underflow");

endmodule

>>> design/skcc_back.sv
// Back: expands queued commands into response beats through an output register.
`timescale 1ns / 1ps

module skcc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  skcc_pkg::cmd_type           head_cmd,
   input  logic                        head_valid,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output skcc_pkg::rsp_beat_type      rsp_data
);

   // Beat within a collision command
   localparam logic [1:0] STEP_HEAD = 2'd0;
   localparam logic [1:0] STEP_HELD = 2'd1;
   localparam logic [1:0] STEP_NEW  = 2'd2;

   logic [1:0]             step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   skcc_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;
   logic                   load;

   assign load      = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Build the next beat from the head command
   always_comb begin
      step_in                  = step_ff;
      pop                      = 1'b0;
      rsp_data_in.result_kind  = skcc_pkg::KIND_TRIPLET;
      rsp_data_in.out_key      = head_cmd.key;
      rsp_data_in.out_position = '0;
      rsp_data_in.out_size     = '0;
      rsp_data_in.out_id       = '0;
      rsp_data_in.last_of_run  = 1'b1;
      unique case (head_cmd.op)
         skcc_pkg::OP_UNIQUE: begin
            rsp_data_in.out_position = head_cmd.position;
            rsp_data_in.out_size     = head_cmd.size;
            pop                      = load;
         end
         skcc_pkg::OP_COLLIDE: begin
            unique case (step_ff)
               STEP_HEAD: begin
                  rsp_data_in.last_of_run = 1'b0;
                  if (load) begin
                     step_in = STEP_HELD;
                  end
               end
               STEP_HELD: begin
                  rsp_data_in.result_kind = skcc_pkg::KIND_ID;
                  rsp_data_in.out_id      = head_cmd.first_id;
                  rsp_data_in.last_of_run = 1'b0;
                  if (load) begin
                     step_in = STEP_NEW;
                  end
               end
               default: begin
                  rsp_data_in.result_kind = skcc_pkg::KIND_ID;
                  rsp_data_in.out_id      = head_cmd.second_id;
                  pop                     = load;
                  if (load) begin
                     step_in = STEP_HEAD;
                  end
               end
            endcase
         end
         default: begin
            rsp_data_in.result_kind = skcc_pkg::KIND_ID;
            rsp_data_in.out_id      = head_cmd.first_id;
            pop                     = load;
         end
      endcase
   end

   // Hold a beat until taken; drop valid when drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_HEAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Mid-collision steps only occur with a collision command at the head
   a_step_owner: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_HEAD) |-> (head_valid && head_cmd.op == skcc_pkg::OP_COLLIDE))
      else $error("collision step without collision command");

   // A command leaves the queue only with its final beat
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid_ff && rsp_data_ff.last_of_run))
      else $error("pop without final beat");

endmodule

>>> tb/tb_sorted_key_collision_classifier.sv
// Testbench for the sorted key collision classifier: sorted record streams checked beat by beat.
`timescale 1ns / 1ps

module tb_sorted_key_collision_classifier;

   typedef struct {
      skcc_pkg::req_beat_type beat;
      bit                     drain_first;
   } stream_item_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   skcc_pkg::req_beat_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   skcc_pkg::rsp_beat_type rsp_data;

   // Records waiting to be sent, and beats the block still owes
   stream_item_type        stream_items[$];
   skcc_pkg::rsp_beat_type owed_beats[$];

   // Mirror of the held slot and the collision run
   logic [63:0] grp_key  = '0;
   logic [63:0] grp_id   = '0;
   logic [31:0] grp_pos  = '0;
   logic [15:0] grp_size = '0;
   bit          grp_run  = 1'b0;

   int errors       = 0;
   int req_taken    = 0;
   int rsp_taken    = 0;
   int send_idle    = 0;
   int take_idle    = 0;
   int send_gap_pct = 0;
   int take_gap_pct = 0;
   bit wind_down      = 1'b0;
   bit long_hold      = 1'b0;
   bit long_hold_done = 1'b0;

   sorted_key_collision_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic skcc_pkg::rsp_beat_type make_beat(logic kind, logic [63:0] key,
                                                        logic [31:0] pos, logic [15:0] size,
                                                        logic [63:0] id, logic last);
      skcc_pkg::rsp_beat_type b;
      b.result_kind  = kind;
      b.out_key      = key;
      b.out_position = pos;
      b.out_size     = size;
      b.out_id       = id;
      b.last_of_run  = last;
      return b;
   endfunction

   // Append one beat to the owed list
   task automatic owe_beat(input skcc_pkg::rsp_beat_type b);
      owed_beats = {owed_beats, b};
   endtask

   task automatic hold_record(input skcc_pkg::req_beat_type r);
      grp_key  = r.minimizer_key;
      grp_id   = r.record_id;
      grp_pos  = r.position;
      grp_size = r.bucket_size;
   endtask

   // Advance the grouping state by one accepted beat and queue the beats it causes
   task automatic group_record(input skcc_pkg::req_beat_type r);
      if (r.req_type == skcc_pkg::REQ_FLUSH) begin
         if (!grp_run && grp_size != 0)
            owe_beat(make_beat(skcc_pkg::KIND_TRIPLET, grp_key, grp_pos, grp_size, '0, 1'b1));
         grp_key  = '0;
         grp_id   = '0;
         grp_pos  = '0;
         grp_size = '0;
         grp_run  = 1'b0;
      end else if (grp_run) begin
         if (r.minimizer_key == grp_key) begin
            owe_beat(make_beat(skcc_pkg::KIND_ID, grp_key, '0, '0, r.record_id, 1'b1));
         end else begin
            grp_run = 1'b0;
            hold_record(r);
         end
      end else if (grp_size != 0) begin
         if (r.minimizer_key == grp_key) begin
            owe_beat(make_beat(skcc_pkg::KIND_TRIPLET, grp_key, '0, '0, '0, 1'b0));
            owe_beat(make_beat(skcc_pkg::KIND_ID, grp_key, '0, '0, grp_id, 1'b0));
            owe_beat(make_beat(skcc_pkg::KIND_ID, grp_key, '0, '0, r.record_id, 1'b1));
            grp_pos  = '0;
            grp_size = '0;
            grp_run  = 1'b1;
         end else begin
            owe_beat(make_beat(skcc_pkg::KIND_TRIPLET, grp_key, grp_pos, grp_size, '0, 1'b1));
            hold_record(r);
         end
      end else begin
         hold_record(r);
      end
   endtask

   task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
      errors++;
   endtask

   // Compare one result beat with the oldest owed beat
   task automatic check_beat(input skcc_pkg::rsp_beat_type got);
      skcc_pkg::rsp_beat_type want;
      if (owed_beats.size() == 0) begin
         $display("%0t unexpected beat: expected none, actual %h", $time, got);
         errors++;
      end else begin
         want = owed_beats.pop_front();
         if (got.result_kind !== want.result_kind)
            report_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
         if (got.out_key !== want.out_key)
            report_field("out_key", want.out_key, got.out_key);
         if (got.out_position !== want.out_position)
            report_field("out_position", 64'(want.out_position), 64'(got.out_position));
         if (got.out_size !== want.out_size)
            report_field("out_size", 64'(want.out_size), 64'(got.out_size));
         if (got.out_id !== want.out_id)
            report_field("out_id", want.out_id, got.out_id);
         if (got.last_of_run !== want.last_of_run)
            report_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
      end
   endtask

   task automatic add_item(logic kind, logic [63:0] key, logic [63:0] id, logic [31:0] pos,
                           logic [15:0] size, bit drain);
      stream_item_type s;
      s.beat.req_type      = kind;
      s.beat.minimizer_key = key;
      s.beat.record_id     = id;
      s.beat.position      = pos;
      s.beat.bucket_size   = size;
      s.drain_first        = drain;
      stream_items = {stream_items, s};
   endtask

   // Driver: offer the next record, hold it until accepted, idle in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            group_record(req_data);
            req_taken++;
            if (req_taken % 40 == 0)
               send_gap_pct = 15 * $urandom_range(0, 2);
         end
         if (!req_valid || req_ready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (stream_items.size() == 0) begin
               req_valid <= 1'b0;
            end else if (stream_items[0].drain_first && owed_beats.size() != 0) begin
               req_valid <= 1'b0;
            end else if (!wind_down && !long_hold && $urandom_range(0, 99) < send_gap_pct) begin
               send_idle = $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else begin
               req_data  <= stream_items[0].beat;
               req_valid <= 1'b1;
               void'(stream_items.pop_front());
            end
         end
         wind_down <= (stream_items.size() < 40);
      end
   end

   // Monitor: take result beats, check them, stall in bursts and once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_beat(rsp_data);
            rsp_taken++;
            if (rsp_taken % 40 == 0)
               take_gap_pct = 15 * $urandom_range(0, 2);
         end
         if (take_idle > 0) begin
            take_idle--;
            rsp_ready <= 1'b0;
            if (take_idle == 0)
               long_hold <= 1'b0;
         end else if (!long_hold_done && req_taken >= 120) begin
            long_hold_done = 1'b1;
            long_hold <= 1'b1;
            take_idle = 79;
            rsp_ready <= 1'b0;
         end else if (!wind_down && $urandom_range(0, 99) < take_gap_pct) begin
            take_idle = $urandom_range(0, 14);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic [63:0] key;
      logic [15:0] size;
      int          len;
      bit          noisy;

      // Extremes, held empty slot, collisions and flushes
      add_item(skcc_pkg::REQ_RECORD, 64'd0, 64'd0, 32'd0, 16'd1, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, '1, '1, '1, '1, 1'b0);
      add_item(skcc_pkg::REQ_FLUSH, '1, '1, '1, '1, 1'b0);
      add_item(skcc_pkg::REQ_FLUSH, '0, '0, '0, '0, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd5, 64'h11, 32'd100, 16'd3, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd5, 64'h22, 32'd200, 16'd0, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd5, 64'h33, 32'd300, 16'd9, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd6, 64'h44, 32'd400, 16'd2, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd7, 64'h55, 32'd500, 16'd0, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd7, 64'h66, 32'd600, 16'd4, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd8, 64'h77, 32'd700, 16'd5, 1'b0);
      add_item(skcc_pkg::REQ_FLUSH, 64'd8, 64'h88, 32'd800, 16'd6, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd9, 64'h99, 32'd900, 16'd1, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd9, 64'haa, 32'd901, 16'd1, 1'b0);
      add_item(skcc_pkg::REQ_FLUSH, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
               16'd7, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd20, 64'hbb, 32'd1, 16'd7, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd10, 64'hcc, 32'd2, 16'd7, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, 64'd20, 64'hdd, 32'd3, 16'd7, 1'b0);
      add_item(skcc_pkg::REQ_FLUSH, '0, '0, '0, '0, 1'b1);
      add_item(skcc_pkg::REQ_RECORD, 64'd30, 64'hee, 32'd4, 16'd0, 1'b0);
      add_item(skcc_pkg::REQ_FLUSH, '0, '0, '0, '0, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, {16{4'h5}}, {16{4'ha}}, {8{4'h5}}, {4{4'ha}}, 1'b0);
      add_item(skcc_pkg::REQ_RECORD, {16{4'ha}}, {16{4'h5}}, {8{4'ha}}, {4{4'h5}}, 1'b0);
      add_item(skcc_pkg::REQ_FLUSH, '0, '0, '0, '0, 1'b0);

      // Random sorted streams with repeats, a few unsorted ones as noise
      while (stream_items.size() < 340) begin
         noisy = ($urandom_range(0, 9) == 0);
         len   = $urandom_range(1, 12);
         key   = {$urandom, $urandom};
         for (int i = 0; i < len; i++) begin
            if (noisy) begin
               key = {$urandom, $urandom};
            end else if (i > 0) begin
               case ($urandom_range(0, 4))
                  2: key += 64'($urandom_range(1, 3));
                  3: key += 64'($urandom);
                  4: key += {$urandom, $urandom} >> 4;
                  default: ;
               endcase
            end
            if ($urandom_range(0, 9) == 0)
               size = '0;
            else if ($urandom_range(0, 9) == 0)
               size = '1;
            else
               size = 16'($urandom_range(1, 65535));
            add_item(skcc_pkg::REQ_RECORD, key, {$urandom, $urandom}, $urandom, size,
                     $urandom_range(0, 49) == 0);
         end
         if ($urandom_range(0, 4) != 0)
            add_item(skcc_pkg::REQ_FLUSH, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                     16'($urandom_range(0, 65535)), 1'b0);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (stream_items.size() != 0 || req_valid);
      do @(negedge clock); while (owed_beats.size() != 0);
      repeat (20) @(negedge clock);

      if (errors == 0)
         $display("tb_sorted_key_collision_classifier OK");
      else
         $display("tb_sorted_key_collision_classifier NOT OK");
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #2000000;
      $display("%0t timeout", $time);
      $display("tb_sorted_key_collision_classifier NOT OK");
      $finish;
   end

endmodule
